>>> hdl/efm_pkg.sv
// shared types, constants and mapping tables for the theremin controller
`default_nettype none
package efm_pkg;

  // fixed design constants
  localparam int BAR_PIXELS        = 10;
  localparam int SAMPLES_PER_FRAME = 3;
  localparam int ECHO_SLOTS        = 3;
  localparam int USED_SAMPLES      = (SAMPLES_PER_FRAME < ECHO_SLOTS) ?
                                     SAMPLES_PER_FRAME : ECHO_SLOTS;

  localparam int ECHO_W  = 16;
  localparam int SUM_W   = 18;
  localparam int CNT_W   = 2;
  localparam int MILLI_W = 21;
  localparam int CM_W    = 6;

  // configuration register indexes
  localparam logic REG_ECHO_MIN = 1'b0;
  localparam logic REG_ECHO_MAX = 1'b1;

  localparam logic [ECHO_W-1:0] ECHO_MIN_RESET = 16'd100;
  localparam logic [ECHO_W-1:0] ECHO_MAX_RESET = 16'd20000;

  // item kinds
  localparam logic CMD_FRAME  = 1'b0;
  localparam logic CMD_BUTTON = 1'b1;

  // reciprocal constants: sum / 3, milli / 1000, pot * 140 / 4095
  localparam logic [18:0] DIV3_RECIP  = 19'd349526;
  localparam logic [16:0] MILLI_RECIP = 17'd67109;
  localparam logic [27:0] POT_RECIP   = 28'd146836620;

  // distance window in thousandths of a cm
  localparam logic [MILLI_W-1:0] MILLI_LO = 21'd4000;
  localparam logic [MILLI_W-1:0] PITCH_HI = 21'd50000;
  localparam logic [MILLI_W-1:0] VOL_HI   = 21'd40000;
  localparam logic [CM_W-1:0]    CM_BASE  = 6'd4;

  // bar colours and modes
  localparam logic [1:0] BAR_ORANGE = 2'd3;
  localparam logic [1:0] MODE_LAST  = 2'd2;
  localparam logic [3:0] BAR_MUTE   = (BAR_PIXELS > 15) ? 4'd15 : 4'(BAR_PIXELS);

  typedef struct packed {
    logic        cmd;
    logic [15:0] pitch_echo_a;
    logic [15:0] pitch_echo_b;
    logic [15:0] pitch_echo_c;
    logic [15:0] vol_echo_a;
    logic [15:0] vol_echo_b;
    logic [15:0] vol_echo_c;
    logic [11:0] pot_level;
    logic        colour_button;
    logic        mute_button;
  } in_item_t;

  typedef struct packed {
    logic [10:0] tone_hz;
    logic [7:0]  volume_duty;
    logic [3:0]  bar_count;
    logic [1:0]  bar_colour;
    logic [1:0]  colour_mode;
    logic        is_muted;
  } out_item_t;

  // what one sensor lane found
  typedef struct packed {
    logic               valid;
    logic [MILLI_W-1:0] milli;
    logic [CM_W-1:0]    cm;
  } lane_res_t;

  // tone from whole-cm distance above 4 cm
  function automatic logic [10:0] tone_of(input logic [CM_W-1:0] x);
    int t;
    t = 50;
    for (int i = 0; i < 64; i++) begin
      if (x == 6'(i)) t = (i * 980) / 46 + 220;
    end
    if (t < 50) t = 50;
    if (t > 2000) t = 2000;
    return t[10:0];
  endfunction

  // duty from whole-cm volume distance above 4 cm
  function automatic logic [7:0] duty_of(input logic [CM_W-1:0] x);
    int d;
    d = 0;
    for (int i = 0; i < 64; i++) begin
      if (x == 6'(i)) d = (i * 125) / 36 + 15;
    end
    if (d < 0) d = 0;
    if (d > 140) d = 140;
    return d[7:0];
  endfunction

  // bar length shrinks with distance, truncated toward zero
  function automatic logic [3:0] bar_of(input logic [CM_W-1:0] x);
    int b;
    b = 1;
    for (int i = 0; i < 64; i++) begin
      if (x == 6'(i)) b = (i * (1 - BAR_PIXELS)) / 41 + BAR_PIXELS;
    end
    if (b < 1) b = 1;
    if (b > BAR_PIXELS) b = BAR_PIXELS;
    if (b > 15) b = 15;
    return b[3:0];
  endfunction

endpackage
`default_nettype wire

>>> hdl/efm_lane.sv
// one sensor lane: echo gating, averaging, distance and whole centimetres
`default_nettype none
module efm_lane (
  input  wire logic                                 clk,
  input  wire logic [efm_pkg::ECHO_SLOTS-1:0][15:0] echoes,
  input  wire logic [15:0]                          echo_min,
  input  wire logic [15:0]                          echo_max,
  output efm_pkg::lane_res_t                        res
);
  import efm_pkg::*;

  logic [SUM_W-1:0]   sum_c;
  logic [CNT_W-1:0]   cnt_c;
  logic [SUM_W-1:0]   sum_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [36:0]        prod3;
  logic [ECHO_W-1:0]  avg_c;
  logic [ECHO_W-1:0]  avg_q;
  logic               avg_ok;
  logic [MILLI_W-1:0] milli_q;
  logic               milli_ok;
  logic [32:0]        prod_cm;

  // gate echoes to the open window and accumulate
  always_comb begin
    sum_c = '0;
    cnt_c = '0;
    for (int i = 0; i < USED_SAMPLES; i++) begin
      if (echoes[i] > echo_min && echoes[i] < echo_max) begin
        sum_c = sum_c + SUM_W'(echoes[i]);
        cnt_c = cnt_c + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    sum_q <= sum_c;
    cnt_q <= cnt_c;
  end

  // average: divide by a count of one, two or three
  assign prod3 = 37'(sum_q) * 37'(DIV3_RECIP);

  always_comb begin
    unique case (cnt_q)
      2'd1:    avg_c = sum_q[ECHO_W-1:0];
      2'd2:    avg_c = sum_q[ECHO_W:1];
      2'd3:    avg_c = prod3[35:20];
      default: avg_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    avg_q  <= avg_c;
    avg_ok <= (cnt_q != '0);
  end

  // distance in thousandths of a cm: avg * 17
  always_ff @(posedge clk) begin
    milli_q  <= (MILLI_W'(avg_q) << 4) + MILLI_W'(avg_q);
    milli_ok <= avg_ok;
  end

  // whole cm, exact for distances below 64 cm
  assign prod_cm = 33'(milli_q[15:0]) * 33'(MILLI_RECIP);

  always_ff @(posedge clk) begin
    res.valid <= milli_ok;
    res.milli <= milli_q;
    res.cm    <= prod_cm[31:26];
  end

endmodule
`default_nettype wire

>>> hdl/efm_merge.sv
// merging stage: tone, duty and bar mapping, button edges and held results
`default_nettype none
module efm_merge (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               upd,
  input  wire efm_pkg::in_item_t  item,
  input  wire efm_pkg::lane_res_t pitch,
  input  wire efm_pkg::lane_res_t vol,
  output efm_pkg::out_item_t      result
);
  import efm_pkg::*;

  logic [1:0]  mode_q;
  logic        mute_reg;
  logic        colour_prev;
  logic        mute_prev;
  logic [10:0] tone_hold;
  logic [7:0]  duty_hold;
  logic [3:0]  bar_count_hold;
  logic [1:0]  bar_colour_hold;
  logic [39:0] pot_prod;
  logic [7:0]  pot_duty;
  logic        pitch_ok;
  logic        vol_ok;
  logic [CM_W-1:0] pitch_x;
  logic [CM_W-1:0] vol_x;
  logic [7:0]  duty_c;

  // pot fallback duty, registered ahead of the merge
  assign pot_prod = 40'(item.pot_level) * 40'(POT_RECIP);

  always_ff @(posedge clk) begin
    pot_duty <= pot_prod[39:32];
  end

  // range checks and table lookups
  assign pitch_ok = pitch.valid && pitch.milli > MILLI_LO && pitch.milli < PITCH_HI
                    && !mute_reg;
  assign vol_ok   = vol.valid && vol.milli > MILLI_LO && vol.milli < VOL_HI;
  assign pitch_x  = pitch.cm - CM_BASE;
  assign vol_x    = vol.cm - CM_BASE;
  assign duty_c   = vol_ok ? duty_of(vol_x) : pot_duty;

  // held frame results and button state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_q          <= '0;
      mute_reg        <= 1'b0;
      colour_prev     <= 1'b1;
      mute_prev       <= 1'b1;
      tone_hold       <= '0;
      duty_hold       <= '0;
      bar_count_hold  <= '0;
      bar_colour_hold <= '0;
    end else if (upd) begin
      if (item.cmd == CMD_FRAME) begin
        if (pitch_ok) begin
          tone_hold       <= tone_of(pitch_x);
          duty_hold       <= duty_c;
          bar_count_hold  <= bar_of(pitch_x);
          bar_colour_hold <= mode_q;
        end else begin
          tone_hold <= '0;
          duty_hold <= '0;
          if (mute_reg) begin
            bar_count_hold  <= BAR_MUTE;
            bar_colour_hold <= BAR_ORANGE;
          end else begin
            bar_count_hold  <= '0;
            bar_colour_hold <= mode_q;
          end
        end
      end else begin
        if (colour_prev && !item.colour_button) begin
          mode_q <= (mode_q >= MODE_LAST) ? 2'd0 : mode_q + 2'd1;
        end
        colour_prev <= item.colour_button;
        if (mute_prev && !item.mute_button) begin
          mute_reg <= !mute_reg;
        end
        mute_prev <= item.mute_button;
      end
    end
  end

  assign result.tone_hz     = tone_hold;
  assign result.volume_duty = duty_hold;
  assign result.bar_count   = bar_count_hold;
  assign result.bar_colour  = bar_colour_hold;
  assign result.colour_mode = mode_q;
  assign result.is_muted    = mute_reg;

  // a muted frame always shows the orange bar
  a_mute_orange: assert property (@(posedge clk) disable iff (rst)
    upd && item.cmd == CMD_FRAME && mute_reg |=> bar_colour_hold == BAR_ORANGE)
    else $error("muted frame without orange bar");

  // a muted frame is silent
  a_mute_silent: assert property (@(posedge clk) disable iff (rst)
    upd && item.cmd == CMD_FRAME && mute_reg |=> tone_hold == '0 && duty_hold == '0)
    else $error("muted frame not silent");

  // only a button item moves the colour mode
  a_mode_hold: assert property (@(posedge clk) disable iff (rst)
    !(upd && item.cmd == CMD_BUTTON) |=> $stable(mode_q) || $past(rst))
    else $error("colour mode changed without a button request");

  // colour mode stays within its three values
  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    mode_q <= MODE_LAST)
    else $error("colour mode out of range");

endmodule
`default_nettype wire

>>> hdl/echo_filter_tone_bar_mapper.sv
// theremin controller top level: config registers, sequencer, lanes, merge, output register
// an accepted request steps through S1..S4 (the four-stage lanes), MERGE and DONE;
// DONE loads the output register once it is free; new requests are taken only in idle
// the output register holds a result while the next request is taken
// reset (synchronous, active high): idle, no result, mode 0, unmuted, holds zero,
// echo window back to 100..20000 us
`default_nettype none
module echo_filter_tone_bar_mapper (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [15:0]       cfg_data,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire efm_pkg::in_item_t item,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output efm_pkg::out_item_t     result
);
  import efm_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_S1    = 7'b0000010,
    ST_S2    = 7'b0000100,
    ST_S3    = 7'b0001000,
    ST_S4    = 7'b0010000,
    ST_MERGE = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [15:0] echo_min;
  logic [15:0] echo_max;
  in_item_t   item_q;
  lane_res_t  pitch_res;
  lane_res_t  vol_res;
  out_item_t  merged;
  logic       load;
  logic [ECHO_SLOTS-1:0][15:0] pitch_echoes;
  logic [ECHO_SLOTS-1:0][15:0] vol_echoes;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      echo_min <= ECHO_MIN_RESET;
      echo_max <= ECHO_MAX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ECHO_MIN: echo_min <= cfg_data;
        REG_ECHO_MAX: echo_max <= cfg_data;
        default:      echo_min <= echo_min;
      endcase
    end
  end

  // request capture
  assign item_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) item_q <= item;
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (item_valid) state_next = ST_S1;
      ST_S1:    state_next = ST_S2;
      ST_S2:    state_next = ST_S3;
      ST_S3:    state_next = ST_S4;
      ST_S4:    state_next = ST_MERGE;
      ST_MERGE: state_next = ST_DONE;
      ST_DONE:  if (!result_valid || result_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // sensor lanes
  assign pitch_echoes = {item_q.pitch_echo_c, item_q.pitch_echo_b, item_q.pitch_echo_a};
  assign vol_echoes   = {item_q.vol_echo_c, item_q.vol_echo_b, item_q.vol_echo_a};

  efm_lane u_pitch_lane (
    .clk      (clk),
    .echoes   (pitch_echoes),
    .echo_min (echo_min),
    .echo_max (echo_max),
    .res      (pitch_res)
  );

  efm_lane u_vol_lane (
    .clk      (clk),
    .echoes   (vol_echoes),
    .echo_min (echo_min),
    .echo_max (echo_max),
    .res      (vol_res)
  );

  // merging stage
  efm_merge u_merge (
    .clk    (clk),
    .rst    (rst),
    .upd    (state == ST_MERGE),
    .item   (item_q),
    .pitch  (pitch_res),
    .vol    (vol_res),
    .result (merged)
  );

  // output register
  assign load = (state == ST_DONE) && (!result_valid || result_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) result <= merged;
  end

  // an accepted request starts the lanes
  a_start: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> state == ST_S1)
    else $error("accepted request did not start the lanes");

  // a fresh result comes only from the done state
  a_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_DONE)
    else $error("result appeared outside the done state");

  // merge is followed by done
  a_merge: assert property (@(posedge clk) disable iff (rst)
    state == ST_MERGE |=> state == ST_DONE)
    else $error("merge not followed by done");

  // a waiting result is never overwritten
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("pending result lost");

endmodule
`default_nettype wire

>>> tb/echo_filter_tone_bar_mapper_tb.sv
// testbench for the theremin controller: directed and random requests, scoreboard checks
`timescale 1ns / 1ps
module echo_filter_tone_bar_mapper_tb;
  import efm_pkg::*;

  // tracks controller state and predicts each readout
  class readout_board;
    logic [15:0] win_min;
    logic [15:0] win_max;
    logic [1:0]  mode;
    logic        muted;
    logic        colour_prev;
    logic        mute_prev;
    out_item_t   held;
    out_item_t   readouts_due[$];
    int          errors;
    int          checked;

    function new();
      win_min     = ECHO_MIN_RESET;
      win_max     = ECHO_MAX_RESET;
      mode        = '0;
      muted       = 1'b0;
      colour_prev = 1'b1;
      mute_prev   = 1'b1;
      held        = '0;
      errors      = 0;
      checked     = 0;
    endfunction

    function int clip(input int v, input int lo, input int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    // gated average of the used echoes, in thousandths of a cm
    function bit echo_milli(input logic [15:0] a, b, c, output int unsigned milli);
      logic [15:0] e [3];
      int unsigned sum;
      int unsigned cnt;
      e = '{a, b, c};
      sum = 0;
      cnt = 0;
      milli = 0;
      for (int i = 0; i < USED_SAMPLES; i++) begin
        if (e[i] > win_min && e[i] < win_max) begin
          sum += e[i];
          cnt++;
        end
      end
      if (cnt == 0) return 1'b0;
      milli = (sum / cnt) * 17;
      return 1'b1;
    endfunction

    // note an accepted request and queue the readout it causes
    function void take_request(input in_item_t x);
      int unsigned pm;
      int unsigned vm;
      bit pv;
      bit vv;
      int d;
      int v;
      int t;
      int du;
      int b;
      out_item_t r;
      if (x.cmd == CMD_FRAME) begin
        pv = echo_milli(x.pitch_echo_a, x.pitch_echo_b, x.pitch_echo_c, pm);
        vv = echo_milli(x.vol_echo_a, x.vol_echo_b, x.vol_echo_c, vm);
        if (pv && pm > 4000 && pm < 50000 && !muted) begin
          d = pm / 1000;
          t = clip(((d - 4) * 980) / 46 + 220, 50, 2000);
          if (vv && vm > 4000 && vm < 40000) begin
            v = vm / 1000;
            du = ((v - 4) * 125) / 36 + 15;
          end else begin
            du = (int'(x.pot_level) * 140) / 4095;
          end
          du = clip(du, 0, 140);
          b = ((d - 4) * (1 - BAR_PIXELS)) / 41 + BAR_PIXELS;
          b = clip(clip(b, 1, BAR_PIXELS), 0, 15);
          held.tone_hz     = t[10:0];
          held.volume_duty = du[7:0];
          held.bar_count   = b[3:0];
          held.bar_colour  = mode;
        end else begin
          held.tone_hz     = '0;
          held.volume_duty = '0;
          if (muted) begin
            held.bar_count  = BAR_MUTE;
            held.bar_colour = BAR_ORANGE;
          end else begin
            held.bar_count  = '0;
            held.bar_colour = mode;
          end
        end
      end else begin
        // falling edges only
        if (colour_prev && !x.colour_button)
          mode = (mode >= MODE_LAST) ? 2'd0 : mode + 2'd1;
        colour_prev = x.colour_button;
        if (mute_prev && !x.mute_button)
          muted = !muted;
        mute_prev = x.mute_button;
      end
      r = held;
      r.colour_mode = mode;
      r.is_muted    = muted;
      readouts_due.push_back(r);
    endfunction

    function void check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    // compare one readout with the oldest prediction
    function void check_readout(input out_item_t got);
      out_item_t want;
      checked++;
      if (readouts_due.size() == 0) begin
        $error("readout with nothing pending: %p", got);
        errors++;
        return;
      end
      want = readouts_due.pop_front();
      check_field("tone_hz", want.tone_hz, got.tone_hz);
      check_field("volume_duty", want.volume_duty, got.volume_duty);
      check_field("bar_count", want.bar_count, got.bar_count);
      check_field("bar_colour", want.bar_colour, got.bar_colour);
      check_field("colour_mode", want.colour_mode, got.colour_mode);
      check_field("is_muted", want.is_muted, got.is_muted);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;
  logic        item_valid;
  logic        item_ready;
  in_item_t    item;
  logic        result_valid;
  logic        result_ready;
  out_item_t   result;

  readout_board board;
  int          burst_left;
  bit          held_off;

  echo_filter_tone_bar_mapper uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #1 clk = ~clk;

  // watch both handshakes
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) board.check_readout(result);
      if (item_valid && item_ready) board.take_request(item);
    end
  end

  function automatic in_item_t frame(input logic [15:0] pa, pb, pc, va, vb, vc,
                                     input logic [11:0] pot);
    in_item_t x;
    x = '0;
    x.cmd           = CMD_FRAME;
    x.pitch_echo_a  = pa;
    x.pitch_echo_b  = pb;
    x.pitch_echo_c  = pc;
    x.vol_echo_a    = va;
    x.vol_echo_b    = vb;
    x.vol_echo_c    = vc;
    x.pot_level     = pot;
    x.colour_button = 1'($urandom_range(0, 1));
    x.mute_button   = 1'($urandom_range(0, 1));
    return x;
  endfunction

  // button sample, echo fields are noise
  function automatic in_item_t buttons(input logic cb, input logic mb);
    in_item_t x;
    x = frame(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
              12'($urandom_range(0, 4095)));
    x.cmd           = CMD_BUTTON;
    x.colour_button = cb;
    x.mute_button   = mb;
    return x;
  endfunction

  // mostly echoes that land in the playing range, some edges and noise
  function automatic logic [15:0] pick_echo(input bit for_volume);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 16'($urandom_range(0, 65535));
      2: begin
        case ($urandom_range(0, 3))
          0: return board.win_min;
          1: return board.win_min + 16'd1;
          2: return board.win_max - 16'd1;
          default: return board.win_max;
        endcase
      end
      default: return 16'($urandom_range(200, for_volume ? 2400 : 3000));
    endcase
  endfunction

  function automatic in_item_t random_request();
    if ($urandom_range(0, 3) == 0)
      return buttons(1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0);
    return frame(pick_echo(1'b0), pick_echo(1'b0), pick_echo(1'b0),
                 pick_echo(1'b1), pick_echo(1'b1), pick_echo(1'b1),
                 12'($urandom_range(0, 4095)));
  endfunction

  // offer one request, hold it until taken, then maybe pause
  task automatic send_request(input in_item_t x);
    item       <= x;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(0, 12);
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // stop sending and let every pending readout come back
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    for (int n = 0; n < 5000 && board.readouts_due.size() != 0; n++) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_window(input logic [15:0] lo, input logic [15:0] hi);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_ECHO_MIN;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= REG_ECHO_MAX;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.win_min = lo;
    board.win_max = hi;
  endtask

  // receiver stalls on its own pattern, with one long hold-off
  initial begin : receiver
    int period;
    int stall;
    int chunk;
    result_ready = 1'b0;
    held_off = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      period = $urandom_range(1, 8);
      stall  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, period - 1);
      chunk  = $urandom_range(20, 120);
      for (int c = 0; c < chunk; c++) begin
        result_ready <= ((c % period) >= stall);
        @(posedge clk);
      end
      if (!held_off && board.checked >= 200) begin
        held_off = 1'b1;
        result_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
    end
  end

  // directed requests, then random requests over several echo windows
  initial begin : stimulus
    in_item_t    script[$];
    logic [15:0] lo_tab [9];
    logic [15:0] hi_tab [9];
    int          count_tab [9];
    board = new();
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = REG_ECHO_MIN;
    cfg_data   = '0;
    item_valid = 1'b0;
    item       = '0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // no valid echo, then echoes past the window
    script.push_back(frame(0, 0, 0, 0, 0, 0, 0));
    script.push_back(frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                           12'hFFF));
    // nearest and farthest playing distance, pot and volume extremes
    script.push_back(frame(236, 236, 236, 0, 0, 0, 12'hFFF));
    script.push_back(frame(2941, 2941, 2941, 2352, 2352, 2352, 0));
    script.push_back(frame(235, 235, 235, 236, 236, 236, 2048));
    script.push_back(frame(2942, 2942, 2942, 235, 235, 235, 1));
    // window edges are excluded, averaging truncates
    script.push_back(frame(100, 20000, 1000, 101, 19999, 2000, 777));
    script.push_back(frame(1000, 1001, 1003, 500, 0, 16'hFFFF, 100));
    // colour mode cycles and wraps
    script.push_back(buttons(1'b0, 1'b1));
    script.push_back(frame(1500, 1500, 1500, 0, 0, 0, 3000));
    script.push_back(buttons(1'b1, 1'b1));
    script.push_back(buttons(1'b0, 1'b1));
    script.push_back(frame(0, 0, 0, 0, 0, 0, 0));
    script.push_back(buttons(1'b0, 1'b1));
    script.push_back(buttons(1'b1, 1'b1));
    script.push_back(buttons(1'b0, 1'b1));
    // mute toggles only on a falling edge; muted frames show the orange bar
    script.push_back(buttons(1'b1, 1'b0));
    script.push_back(frame(1500, 1500, 1500, 1000, 1000, 1000, 4000));
    script.push_back(buttons(1'b1, 1'b0));
    script.push_back(frame(0, 0, 0, 0, 0, 0, 0));
    script.push_back(buttons(1'b1, 1'b1));
    script.push_back(buttons(1'b1, 1'b0));
    script.push_back(frame(800, 0, 900, 400, 450, 0, 12'hFFF));
    foreach (script[i]) send_request(script[i]);

    // window settings: reset values, widest, empty, narrow, mid-range, random, reset again
    lo_tab    = '{16'd100, 16'd0, 16'hFFFF, 16'd500, 16'd0, 16'd1000,
                  16'($urandom_range(0, 1500)), 16'($urandom_range(0, 1500)), 16'd100};
    hi_tab    = '{16'd20000, 16'hFFFF, 16'd0, 16'd501, 16'd1, 16'd3000,
                  16'($urandom_range(1500, 30000)), 16'($urandom_range(1500, 65535)),
                  16'd20000};
    count_tab = '{120, 120, 30, 30, 30, 120, 120, 120, 110};
    for (int p = 0; p < 9; p++) begin
      write_window(lo_tab[p], hi_tab[p]);
      repeat (count_tab[p]) send_request(random_request());
    end

    drain();
    if (board.readouts_due.size() != 0) begin
      $error("%0d readouts never arrived", board.readouts_due.size());
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("echo_filter_tone_bar_mapper_tb: clean");
    end else begin
      $display("echo_filter_tone_bar_mapper_tb: errors");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    #2000000;
    $display("echo_filter_tone_bar_mapper_tb: errors");
    $finish;
  end

endmodule
